/* rtl/simple_machine_instruction_execute_macros.svh */
// Assertion macros shared by the RTL.
`ifndef SIMPLE_MACHINE_INSTRUCTION_EXECUTE_MACROS_SVH
`define SIMPLE_MACHINE_INSTRUCTION_EXECUTE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SMIE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SMIE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SMIE_ASSERT_IMPL(label, clk, rstn, ante, cons)

`define SMIE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* rtl/smie_pkg.sv */
`timescale 1ns / 1ps

package smie_pkg;

    localparam int REG_COUNT  = 16;
    localparam int MEM_CELLS  = 256;
    localparam int REG_AW     = 4;
    localparam int MEM_AW     = 8;
    localparam int DATA_W     = 8;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_IMM   = 4'd2;
    localparam logic [3:0] OP_STORE = 4'd3;
    localparam logic [3:0] OP_MOVE  = 4'd4;
    localparam logic [3:0] OP_ADD   = 4'd5;
    localparam logic [3:0] OP_JUMP  = 4'd11;
    localparam logic [3:0] OP_HALT  = 4'd12;

    localparam logic [REG_AW-1:0] REG_ZERO = '0;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] a_addr;
        logic [REG_AW-1:0] b_addr;
        logic [MEM_AW-1:0] m_addr;
    } smie_rd_t;

    typedef struct packed {
        logic              commit;
        logic              reg_we;
        logic [REG_AW-1:0] reg_idx;
        logic [DATA_W-1:0] reg_val;
        logic              mem_we;
        logic [MEM_AW-1:0] mem_addr;
        logic [DATA_W-1:0] mem_val;
    } smie_wr_t;

    typedef struct packed {
        logic              halted;
        logic [DATA_W-1:0] jump_target;
        logic              jump_taken;
        logic [DATA_W-1:0] mem_value;
        logic [MEM_AW-1:0] mem_address;
        logic              mem_write;
        logic [DATA_W-1:0] reg_value;
        logic [REG_AW-1:0] reg_index;
        logic              reg_write;
    } smie_res_t;

endpackage

/* rtl/simple_machine_instruction_execute.sv */
`timescale 1ns / 1ps
`include "simple_machine_instruction_execute_macros.svh"
//  channel  | direction | tdata fields, lowest bit first
//  s_axis   | in        | opcode, reg_r, operand_xy
//  m_axis   | out       | reg_write, reg_index, reg_value, mem_write, mem_address,
//           |           | mem_value, jump_taken, jump_target, halted
//
//  One request per cycle sustained while m_tready is high. Accepting a request
//  reads the register file and data memory ports; execute then runs it, writes
//  back, forwards the last write to the following request and registers the result.
//  Reset is immediate: per-entry valid bits make both stores read as zero.
//  A stalled result holds in the output register; one request waits in execute.

module simple_machine_instruction_execute
    import smie_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // opcode, reg_r, operand_xy
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // reg_write, reg_index, reg_value,
                                              // mem_write, mem_address, mem_value,
                                              // jump_taken, jump_target, halted
);

    logic              s1_valid_reg;
    logic [3:0]        s1_op_reg;
    logic [REG_AW-1:0] s1_r_reg;
    logic [7:0]        s1_xy_reg;
    logic              out_valid_reg;
    smie_res_t         out_data_reg;
    logic              halt_reg;
    logic              halt_next;

    logic              accept;
    logic              s1_adv;
    logic [3:0]        in_op;
    logic [REG_AW-1:0] in_r;
    logic [7:0]        in_xy;
    smie_rd_t          rd;
    smie_wr_t          wr;
    smie_res_t         res;
    logic [DATA_W-1:0] a_data, b_data, m_data;

    assign in_op = s_tdata[3:0];
    assign in_r  = s_tdata[7:4];
    assign in_xy = s_tdata[15:8];

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        rd.en     = accept;
        rd.a_addr = (in_op == OP_MOVE || in_op == OP_ADD) ? in_xy[7:4] : in_r;
        rd.b_addr = (in_op == OP_ADD) ? in_xy[3:0] : REG_ZERO;
        rd.m_addr = in_xy;
    end

    smie_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rd),
        .wr      (wr),
        .a_data  (a_data),
        .b_data  (b_data),
        .m_data  (m_data)
    );

    always_comb begin
        res       = '0;
        halt_next = halt_reg;
        if (!halt_reg) begin
            unique case (s1_op_reg)
                OP_LOAD: begin
                    res.reg_write = 1'b1;
                    res.reg_index = s1_r_reg;
                    res.reg_value = m_data;
                end
                OP_IMM: begin
                    res.reg_write = 1'b1;
                    res.reg_index = s1_r_reg;
                    res.reg_value = s1_xy_reg;
                end
                OP_STORE: begin
                    res.mem_write   = 1'b1;
                    res.mem_address = s1_xy_reg;
                    res.mem_value   = a_data;
                end
                OP_MOVE: begin
                    res.reg_write = 1'b1;
                    res.reg_index = s1_xy_reg[3:0];
                    res.reg_value = a_data;
                end
                OP_ADD: begin
                    res.reg_write = 1'b1;
                    res.reg_index = s1_r_reg;
                    res.reg_value = a_data + b_data;
                end
                OP_JUMP: begin
                    if (a_data == b_data) begin
                        res.jump_taken  = 1'b1;
                        res.jump_target = s1_xy_reg;
                    end
                end
                OP_HALT: begin
                    halt_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
        res.halted = halt_next;
    end

    always_comb begin
        wr.commit   = s1_adv;
        wr.reg_we   = res.reg_write;
        wr.reg_idx  = res.reg_index;
        wr.reg_val  = res.reg_value;
        wr.mem_we   = res.mem_write;
        wr.mem_addr = res.mem_address;
        wr.mem_val  = res.mem_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            halt_reg      <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
                halt_reg      <= halt_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg <= in_op;
            s1_r_reg  <= in_r;
            s1_xy_reg <= in_xy;
        end
        if (s1_adv) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SMIE_ASSERT_NEXT(a_halt_sticky, aclk, aresetn, halt_reg, halt_reg)
    `SMIE_ASSERT_IMPL(a_halted_no_effect, aclk, aresetn,
        s1_valid_reg && halt_reg,
        !res.reg_write && !res.mem_write && !res.jump_taken)
    `SMIE_ASSERT_IMPL(a_single_effect, aclk, aresetn,
        s1_valid_reg, $countones({res.reg_write, res.mem_write, res.jump_taken}) <= 1)
    `SMIE_ASSERT_NEXT(a_exec_holds_on_stall, aclk, aresetn,
        s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_xy_reg))

endmodule

/* rtl/smie_state.sv */
`timescale 1ns / 1ps
`include "simple_machine_instruction_execute_macros.svh"

module smie_state
    import smie_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  smie_rd_t          rd,
    input  smie_wr_t          wr,
    output logic [DATA_W-1:0] a_data,
    output logic [DATA_W-1:0] b_data,
    output logic [DATA_W-1:0] m_data
);

    logic [DATA_W-1:0] reg_mem_reg  [REG_COUNT];
    logic [DATA_W-1:0] data_mem_reg [MEM_CELLS];
    logic [REG_COUNT-1:0] reg_valid_reg;
    logic [MEM_CELLS-1:0] mem_valid_reg;

    logic [DATA_W-1:0] a_q_reg, b_q_reg, m_q_reg;
    logic              a_v_reg, b_v_reg, m_v_reg;
    logic [REG_AW-1:0] a_addr_reg, b_addr_reg;
    logic [MEM_AW-1:0] m_addr_reg;

    logic              fwd_reg_we_reg;
    logic [REG_AW-1:0] fwd_reg_idx_reg;
    logic [DATA_W-1:0] fwd_reg_val_reg;
    logic              fwd_mem_we_reg;
    logic [MEM_AW-1:0] fwd_mem_addr_reg;
    logic [DATA_W-1:0] fwd_mem_val_reg;

    // read ports, registered
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            a_q_reg    <= reg_mem_reg[rd.a_addr];
            b_q_reg    <= reg_mem_reg[rd.b_addr];
            m_q_reg    <= data_mem_reg[rd.m_addr];
            a_addr_reg <= rd.a_addr;
            b_addr_reg <= rd.b_addr;
            m_addr_reg <= rd.m_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.commit && wr.reg_we) begin
            reg_mem_reg[wr.reg_idx] <= wr.reg_val;
        end
        if (wr.commit && wr.mem_we) begin
            data_mem_reg[wr.mem_addr] <= wr.mem_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_valid_reg  <= '0;
            mem_valid_reg  <= '0;
            a_v_reg        <= 1'b0;
            b_v_reg        <= 1'b0;
            m_v_reg        <= 1'b0;
            fwd_reg_we_reg <= 1'b0;
            fwd_mem_we_reg <= 1'b0;
        end else begin
            if (rd.en) begin
                a_v_reg <= reg_valid_reg[rd.a_addr];
                b_v_reg <= reg_valid_reg[rd.b_addr];
                m_v_reg <= mem_valid_reg[rd.m_addr];
            end
            if (wr.commit) begin
                fwd_reg_we_reg <= wr.reg_we;
                fwd_mem_we_reg <= wr.mem_we;
                if (wr.reg_we) begin
                    reg_valid_reg[wr.reg_idx] <= 1'b1;
                end
                if (wr.mem_we) begin
                    mem_valid_reg[wr.mem_addr] <= 1'b1;
                end
            end
        end
    end

    // last committed write, for a read issued on the same edge
    always_ff @(posedge aclk) begin
        if (wr.commit) begin
            fwd_reg_idx_reg  <= wr.reg_idx;
            fwd_reg_val_reg  <= wr.reg_val;
            fwd_mem_addr_reg <= wr.mem_addr;
            fwd_mem_val_reg  <= wr.mem_val;
        end
    end

    always_comb begin
        if (fwd_reg_we_reg && fwd_reg_idx_reg == a_addr_reg) begin
            a_data = fwd_reg_val_reg;
        end else begin
            a_data = a_v_reg ? a_q_reg : '0;
        end
        if (fwd_reg_we_reg && fwd_reg_idx_reg == b_addr_reg) begin
            b_data = fwd_reg_val_reg;
        end else begin
            b_data = b_v_reg ? b_q_reg : '0;
        end
        if (fwd_mem_we_reg && fwd_mem_addr_reg == m_addr_reg) begin
            m_data = fwd_mem_val_reg;
        end else begin
            m_data = m_v_reg ? m_q_reg : '0;
        end
    end

    `SMIE_ASSERT_IMPL(a_one_store_per_commit, aclk, aresetn,
        wr.commit, !(wr.reg_we && wr.mem_we))
    `SMIE_ASSERT_NEXT(a_reg_valid_sticky, aclk, aresetn,
        wr.commit && wr.reg_we, reg_valid_reg[$past(wr.reg_idx)])
    `SMIE_ASSERT_NEXT(a_mem_valid_sticky, aclk, aresetn,
        wr.commit && wr.mem_we, mem_valid_reg[$past(wr.mem_addr)])

endmodule
